// ----- hdl/tsnb_pkg.sv -----
`timescale 1ns / 1ps
package tsnb_pkg;

   // Fixed field widths
   localparam int COORD_FRAC_BITS = 16;
   localparam int CHANNEL_BITS    = 8;
   localparam int NUM_CH          = 3;
   localparam int TEXEL_W         = NUM_CH * CHANNEL_BITS;
   localparam int WIDX_W          = 12;

   // Image side limits
   localparam int MAX_SIDE = 64;
   localparam int SIDE_W   = 7;
   localparam int IDX_W    = $clog2(MAX_SIDE);
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int POS_W    = COORD_FRAC_BITS + SIDE_W;

   // Blend arithmetic
   localparam int NUM_TAPS = 4;
   localparam int WT_W     = 2 * COORD_FRAC_BITS + 1;
   localparam int PROD_W   = CHANNEL_BITS + WT_W;
   localparam int SUM_W    = PROD_W + 2;

   // Store depth default
   localparam int STORE_DEPTH_DEF = 4096;

   // Stream packing: request tdata, lowest bit up
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_RED_LSB   = REQ_IDX_LSB + WIDX_W;
   localparam int REQ_GREEN_LSB = REQ_RED_LSB + CHANNEL_BITS;
   localparam int REQ_BLUE_LSB  = REQ_GREEN_LSB + CHANNEL_BITS;
   localparam int REQ_U_LSB     = REQ_BLUE_LSB + CHANNEL_BITS;
   localparam int REQ_V_LSB     = REQ_U_LSB + COORD_FRAC_BITS;
   localparam int REQ_USED_W    = REQ_V_LSB + COORD_FRAC_BITS;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = ((TEXEL_W + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIDE_W;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

   localparam logic [SIDE_W-1:0] IMAGE_WIDTH_RST  = 7'd64;
   localparam logic [SIDE_W-1:0] IMAGE_HEIGHT_RST = 7'd64;

   // Item kinds and filter modes
   localparam logic KIND_WRITE     = 1'b0;
   localparam logic KIND_SAMPLE    = 1'b1;
   localparam logic MODE_NEAREST   = 1'b0;
   localparam logic MODE_BILINEAR  = 1'b1;

endpackage

// ----- hdl/texture_sampler_nearest_bilinear.sv -----
`timescale 1ns / 1ps
// Texture sampler with nearest and bilinear filtering over an RGB texel store.
// req channel: one item per transfer. tuser carries the kind (write or sample);
// a write item stores one texel at a row-major index and returns nothing, a
// sample item returns one RGB colour on the rsp channel, in order.
// csr channel: writes image width, image height and filter mode; always ready.
// Change these only while no item is in flight.
// Throughput: one item per cycle unless rsp stalls, writes and samples mixed
// freely. The four neighbour reads come from four copies of the store, each with
// one read port, all written together.
// Stages: a sample reaches rsp through six register stages (coordinate scale,
// neighbour select, address and weights, store read, channel products, sum and
// round into the output register).
// Stall: the whole pipeline holds while rsp_tvalid is high and rsp_tready low;
// req_tready then drops, and nothing in flight is lost or repeated.
// Reset: clears the pipeline valid bits and sets width 64, height 64 and
// nearest mode. Texel contents are undefined until written.
module texture_sampler_nearest_bilinear #(
   parameter int STORE_DEPTH = tsnb_pkg::STORE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: write_index[11:0], write_red[19:12], write_green[27:20],
   //        write_blue[35:28], coord_u[51:36], coord_v[67:52], zero pad
   input  logic [tsnb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: kind
   input  logic                                req_tuser,
   // rsp channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
   output logic [tsnb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // csr channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsnb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tsnb_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CF     = tsnb_pkg::COORD_FRAC_BITS;
   localparam int CH     = tsnb_pkg::CHANNEL_BITS;
   localparam int NCH    = tsnb_pkg::NUM_CH;
   localparam int TW     = tsnb_pkg::TEXEL_W;
   localparam int SW     = tsnb_pkg::SIDE_W;
   localparam int IW     = tsnb_pkg::IDX_W;
   localparam int AW     = tsnb_pkg::ADDR_W;
   localparam int PW     = tsnb_pkg::POS_W;
   localparam int NT     = tsnb_pkg::NUM_TAPS;
   localparam int WW     = tsnb_pkg::WT_W;
   localparam int PRW    = tsnb_pkg::PROD_W;
   localparam int SUW    = tsnb_pkg::SUM_W;
   localparam int XW     = tsnb_pkg::WIDX_W;
   localparam int LINW   = IW + SW;
   localparam int MEM_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam logic [CF:0]    FRAC_ONE = {1'b1, {CF{1'b0}}};
   localparam logic [SUW-1:0] ROUND_HALF = SUW'(1) << (2 * CF - 1);

   typedef struct packed {
      logic          smp;
      logic [XW-1:0] widx;
      logic [TW-1:0] wdata;
      logic [PW-1:0] px;
      logic [PW-1:0] py;
   } s1_type;

   typedef struct packed {
      logic          smp;
      logic [XW-1:0] widx;
      logic [TW-1:0] wdata;
      logic [IW-1:0] x0;
      logic [IW-1:0] x1;
      logic [IW-1:0] r0;
      logic [IW-1:0] r1;
      logic [CF-1:0] fa;
      logic [CF-1:0] fb;
   } s2_type;

   typedef struct packed {
      logic                   smp;
      logic [XW-1:0]          widx;
      logic [TW-1:0]          wdata;
      logic [NT-1:0][AW-1:0]  addr;
      logic [NT-1:0][WW-1:0]  wt;
   } s3_type;

   typedef struct packed {
      logic                   smp;
      logic [NT-1:0]          inr;
      logic [NT-1:0][WW-1:0]  wt;
   } s4_type;

   typedef struct packed {
      logic                             smp;
      logic [NT-1:0][NCH-1:0][PRW-1:0]  prod;
   } s5_type;

   // Configuration registers
   logic [SW-1:0] image_width_ff;
   logic [SW-1:0] image_height_ff;
   logic          filter_mode_ff;

   logic [SW-1:0] width_eff;
   logic [SW-1:0] height_eff;
   logic [SW-1:0] w_last_full;
   logic [SW-1:0] h_last_full;
   logic [IW-1:0] w_last;
   logic [IW-1:0] h_last;

   // Pipeline
   logic                adv;
   logic [5:1]          vld_ff;
   s1_type              s1_ff, s1_in;
   s2_type              s2_ff, s2_in;
   s3_type              s3_ff, s3_in;
   s4_type              s4_ff, s4_in;
   s5_type              s5_ff, s5_in;
   logic [TW-1:0]       texel_ff [NT];
   logic                rsp_valid_ff;
   logic [TW-1:0]       rsp_data_ff, rsp_data_in;

   logic [SW-1:0]       scale_x;
   logic [SW-1:0]       scale_y;
   logic [SW-1:0]       xi;
   logic [SW-1:0]       yi;
   logic [IW-1:0]       x0c, x1c, y0c, y1c;
   logic [CF:0]         ia, ib, fa_ext, fb_ext;
   logic [NT-1:0][LINW-1:0] lin;
   logic [NT-1:0][2*CF+1:0] wt_full;
   logic [NCH-1:0][SUW-1:0] ch_sum;
   logic [31:0]         wr_ext;
   logic                wr_en;

   assign csr_ready  = 1'b1;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tsnb_pkg::RSP_DATA_W'(rsp_data_ff);

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= tsnb_pkg::IMAGE_WIDTH_RST;
         image_height_ff <= tsnb_pkg::IMAGE_HEIGHT_RST;
         filter_mode_ff  <= tsnb_pkg::MODE_NEAREST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tsnb_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            tsnb_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_data;
            tsnb_pkg::REG_FILTER_MODE:  filter_mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamp the image size to 1..MAX_SIDE
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = SW'(1);
      end else if (image_width_ff > SW'(tsnb_pkg::MAX_SIDE)) begin
         width_eff = SW'(tsnb_pkg::MAX_SIDE);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = SW'(1);
      end else if (image_height_ff > SW'(tsnb_pkg::MAX_SIDE)) begin
         height_eff = SW'(tsnb_pkg::MAX_SIDE);
      end else begin
         height_eff = image_height_ff;
      end
      w_last_full = width_eff - SW'(1);
      h_last_full = height_eff - SW'(1);
      w_last      = w_last_full[IW-1:0];
      h_last      = h_last_full[IW-1:0];
   end

   // Stage 1: scale coordinates by size (nearest) or size minus one (bilinear)
   always_comb begin
      scale_x     = (filter_mode_ff == tsnb_pkg::MODE_BILINEAR) ? w_last_full : width_eff;
      scale_y     = (filter_mode_ff == tsnb_pkg::MODE_BILINEAR) ? h_last_full : height_eff;
      s1_in.smp   = (req_tuser == tsnb_pkg::KIND_SAMPLE);
      s1_in.widx  = req_tdata[tsnb_pkg::REQ_IDX_LSB +: XW];
      s1_in.wdata = {req_tdata[tsnb_pkg::REQ_BLUE_LSB +: CH],
                     req_tdata[tsnb_pkg::REQ_GREEN_LSB +: CH],
                     req_tdata[tsnb_pkg::REQ_RED_LSB +: CH]};
      s1_in.px    = PW'(req_tdata[tsnb_pkg::REQ_U_LSB +: CF]) * PW'(scale_x);
      s1_in.py    = PW'(req_tdata[tsnb_pkg::REQ_V_LSB +: CF]) * PW'(scale_y);
   end

   // Stage 2: pick neighbours, clamp, flip rows; nearest uses one texel at full weight
   always_comb begin
      xi  = s1_ff.px[PW-1:CF];
      yi  = s1_ff.py[PW-1:CF];
      x0c = (xi > w_last_full) ? w_last : xi[IW-1:0];
      y0c = (yi > h_last_full) ? h_last : yi[IW-1:0];
      x1c = (filter_mode_ff == tsnb_pkg::MODE_BILINEAR && x0c != w_last) ?
            x0c + IW'(1) : x0c;
      y1c = (filter_mode_ff == tsnb_pkg::MODE_BILINEAR && y0c != h_last) ?
            y0c + IW'(1) : y0c;
      s2_in.smp   = s1_ff.smp;
      s2_in.widx  = s1_ff.widx;
      s2_in.wdata = s1_ff.wdata;
      s2_in.x0    = x0c;
      s2_in.x1    = x1c;
      s2_in.r0    = h_last - y0c;
      s2_in.r1    = h_last - y1c;
      s2_in.fa    = (filter_mode_ff == tsnb_pkg::MODE_BILINEAR) ? s1_ff.px[CF-1:0] : '0;
      s2_in.fb    = (filter_mode_ff == tsnb_pkg::MODE_BILINEAR) ? s1_ff.py[CF-1:0] : '0;
   end

   // Stage 3: store addresses and blend weights; taps are x0y0, x0y1, x1y0, x1y1
   always_comb begin
      lin[0] = LINW'(s2_ff.r0) * LINW'(width_eff) + LINW'(s2_ff.x0);
      lin[1] = LINW'(s2_ff.r1) * LINW'(width_eff) + LINW'(s2_ff.x0);
      lin[2] = LINW'(s2_ff.r0) * LINW'(width_eff) + LINW'(s2_ff.x1);
      lin[3] = LINW'(s2_ff.r1) * LINW'(width_eff) + LINW'(s2_ff.x1);
      fa_ext = {1'b0, s2_ff.fa};
      fb_ext = {1'b0, s2_ff.fb};
      ia     = FRAC_ONE - fa_ext;
      ib     = FRAC_ONE - fb_ext;
      wt_full[0] = (2*CF+2)'(ia) * (2*CF+2)'(ib);
      wt_full[1] = (2*CF+2)'(ia) * (2*CF+2)'(fb_ext);
      wt_full[2] = (2*CF+2)'(fa_ext) * (2*CF+2)'(ib);
      wt_full[3] = (2*CF+2)'(fa_ext) * (2*CF+2)'(fb_ext);
      s3_in.smp   = s2_ff.smp;
      s3_in.widx  = s2_ff.widx;
      s3_in.wdata = s2_ff.wdata;
      for (int k = 0; k < NT; k++) begin
         s3_in.addr[k] = lin[k][AW-1:0];
         s3_in.wt[k]   = wt_full[k][WW-1:0];
      end
   end

   // Stage 4: store access; writes land here so later samples see them
   assign wr_ext = 32'(s3_ff.widx);
   assign wr_en  = vld_ff[3] && !s3_ff.smp && (wr_ext < 32'(STORE_DEPTH));

   always_comb begin
      s4_in.smp = s3_ff.smp;
      s4_in.wt  = s3_ff.wt;
      for (int k = 0; k < NT; k++) begin
         s4_in.inr[k] = (32'(s3_ff.addr[k]) < 32'(STORE_DEPTH));
      end
   end

   for (genvar q = 0; q < NT; q++) begin : g_copy
      logic [TW-1:0] store_mem [STORE_DEPTH];
      logic [31:0]   rd_ext;

      assign rd_ext = 32'(s3_ff.addr[q]);

      // Write every copy together, read one tap from each
      always_ff @(posedge clock) begin
         if (adv) begin
            if (wr_en) begin
               store_mem[wr_ext[MEM_AW-1:0]] <= s3_ff.wdata;
            end
            texel_ff[q] <= store_mem[rd_ext[MEM_AW-1:0]];
         end
      end
   end

   // Stage 5: weight each channel of each tap; out-of-store taps read zero
   always_comb begin
      s5_in.smp = s4_ff.smp;
      for (int k = 0; k < NT; k++) begin
         for (int c = 0; c < NCH; c++) begin
            s5_in.prod[k][c] = s4_ff.inr[k] ?
               PRW'(texel_ff[k][c*CH +: CH]) * PRW'(s4_ff.wt[k]) : '0;
         end
      end
   end

   // Stage 6: sum taps, round half up, drop the fraction
   always_comb begin
      rsp_data_in = '0;
      for (int c = 0; c < NCH; c++) begin
         ch_sum[c] = SUW'(s5_ff.prod[0][c]) + SUW'(s5_ff.prod[1][c]) +
                     SUW'(s5_ff.prod[2][c]) + SUW'(s5_ff.prod[3][c]) + ROUND_HALF;
         rsp_data_in[c*CH +: CH] = ch_sum[c][2*CF +: CH];
      end
   end

   // Advance valid bits; only sample items reach the output
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[4:1], req_tvalid};
         rsp_valid_ff <= vld_ff[5] && s5_ff.smp;
      end
   end

   // Advance payload; hold everything while the output is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_ff       <= s3_in;
         s4_ff       <= s4_in;
         s5_ff       <= s5_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- hdl/tsnb_checker.sv -----
`timescale 1ns / 1ps
module tsnb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [tsnb_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // Reset empties the output register
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled result freezes the pipeline, so no new transfer is taken
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req_tready high while the result is stalled");

   // An empty output register never holds back the input
   a_empty_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with an empty output");

   // A stalled result stays and holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

endmodule

bind texture_sampler_nearest_bilinear tsnb_checker u_tsnb_checker (.*);
